FILE: rtl/dtas_pkg.sv
// Shared constants, types and calendar helpers for the date-time offset unit.
`timescale 1ns / 1ps
package dtas_pkg;

  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [4:0]  HOURS_PER_DAY = 5'd24;
  localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
  localparam logic [5:0]  SECS_MIN_W6   = 6'd60;
  localparam logic [13:0] YEAR_MAX      = 14'd9999;

  // The offset is biased by a whole number of days so that the division
  // by the day length always sees a nonnegative dividend.
  localparam logic [32:0] SEC_BIAS   = 33'd2147558400;  // 24856 days
  localparam logic [17:0] DAY_OFFSET = 18'd24857;       // day bias plus one

  // A day is 2^7 * 675 seconds. After the low 7 bits are split off, the
  // reciprocal of 675 below is exact for every dividend under 2^26.
  localparam logic [26:0] RECIP675       = 27'd101806633;
  localparam int unsigned RECIP675_SHIFT = 36;
  localparam logic [9:0]  DAY_ODD        = 10'd675;

  // Reciprocal of 25 for the year: exact for every 14-bit value.
  localparam logic [27:0] RECIP25     = 28'd5243;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam logic [13:0] YEAR_DIV    = 14'd25;
  localparam logic [4:0]  MOD25_TOP   = 5'd24;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INPUT = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_QUOT,
    OP_MOD,
    OP_START,
    OP_DIV,
    OP_DREM,
    OP_HOUR,
    OP_MIN,
    OP_WINIT,
    OP_WALK,
    OP_RESULT
  } op_t;

  typedef struct packed {
    logic bad;
    logic hour_done;
    logic min_done;
    logic walk_done;
    logic walk_range;
  } dp_status_t;

  // Divisible by 100 is divisible by 4 and 25; by 400 is also by 16.
  function automatic logic is_leap(input logic [3:0] y_lo, input logic [4:0] y_mod25);
    return (y_lo[1:0] == 2'd0) && ((y_mod25 != 5'd0) || (y_lo == 4'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m) inside
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/dtas_ctrl.sv
// Sequencer for the date-time offset unit: steps the datapath and owns the handshakes.
`timescale 1ns / 1ps
module dtas_ctrl import dtas_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t sts,
  output op_t        op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_QUOT,
    S_MOD,
    S_CHECK,
    S_DIV,
    S_DREM,
    S_HOUR,
    S_MIN,
    S_WINIT,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    op = OP_NONE;
    unique case (state)
      S_IDLE:   if (in_valid) op = OP_LOAD;
      S_QUOT:   op = OP_QUOT;
      S_MOD:    op = OP_MOD;
      S_CHECK:  op = OP_START;
      S_DIV:    op = OP_DIV;
      S_DREM:   op = OP_DREM;
      S_HOUR:   op = OP_HOUR;
      S_MIN:    op = OP_MIN;
      S_WINIT:  op = OP_WINIT;
      S_WALK:   op = OP_WALK;
      S_FINISH: if (out_free) op = OP_RESULT;
      default:  op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_QUOT;
        S_QUOT:   state <= S_MOD;
        S_MOD:    state <= S_CHECK;
        S_CHECK:  state <= sts.bad ? S_FINISH : S_DIV;
        S_DIV:    state <= S_DREM;
        S_DREM:   state <= S_HOUR;
        S_HOUR:   if (sts.hour_done) state <= S_MIN;
        S_MIN:    if (sts.min_done) state <= S_WINIT;
        S_WINIT:  state <= S_WALK;
        S_WALK:   if (sts.walk_done || sts.walk_range) state <= S_FINISH;
        S_FINISH: if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/dtas_dp.sv
// Datapath: input check, reciprocal day division, time split and month walk.
`timescale 1ns / 1ps
module dtas_dp import dtas_pkg::*; (
  input  logic        clk,
  input  op_t         op,
  output dp_status_t  sts,
  input  logic [13:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  input  logic [4:0]  hour_in,
  input  logic [5:0]  minute_in,
  input  logic [5:0]  second_in,
  input  logic [31:0] delta_seconds,
  output logic [13:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out,
  output logic [1:0]  status
);

  logic [13:0] yr;
  logic [3:0]  mo;
  logic [4:0]  dy;
  logic [4:0]  hr;
  logic [5:0]  mi;
  logic [5:0]  se;
  logic [31:0] delta;
  logic [9:0]  q25;
  logic [4:0]  ym25;
  logic [16:0] tod0;
  logic [32:0] u;
  logic [16:0] dq;
  logic [16:0] rem;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [17:0] e;
  logic [1:0]  stat;

  logic        leap;
  logic [4:0]  cur_len;
  logic [4:0]  prev_len;
  logic [3:0]  prev_mo;
  logic [3:0]  next_mo;
  logic        e_neg;
  logic        e_over;
  logic [52:0] day_prod;
  logic [25:0] day_sub;

  assign leap     = is_leap(yr[3:0], ym25);
  assign cur_len  = month_len(mo, leap);
  assign prev_mo  = (mo == MON_JAN) ? MON_DEC : mo - 4'd1;
  assign next_mo  = (mo == MON_DEC) ? MON_JAN : mo + 4'd1;
  // Stepping back from January lands in December, whose length ignores leap.
  assign prev_len = month_len(prev_mo, leap);
  assign e_neg    = e[17];
  assign e_over   = !e[17] && (e >= {13'd0, cur_len});
  // The biased seconds drop their low 7 bits, and the rest is divided by 675.
  assign day_prod = {27'd0, u[32:7]} * {26'd0, RECIP675};
  assign day_sub  = u[32:7] - {9'd0, dq} * {16'd0, DAY_ODD};

  always_comb begin
    sts.bad = (yr > YEAR_MAX) || (mo == 4'd0) || (mo > MON_DEC) || (dy == 5'd0) ||
              (dy > cur_len) || (hr >= HOURS_PER_DAY) || (mi >= MINS_PER_HOUR) ||
              (se >= SECS_MIN_W6);
    sts.hour_done  = (rem < SECS_PER_HOUR);
    sts.min_done   = (rem < SECS_PER_MIN);
    sts.walk_done  = !e_neg && !e_over;
    sts.walk_range = (e_neg && (mo == MON_JAN) && (yr == 14'd0)) ||
                     (e_over && (mo == MON_DEC) && (yr == YEAR_MAX));
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        yr    <= year_in;
        mo    <= month_in;
        dy    <= day_in;
        hr    <= hour_in;
        mi    <= minute_in;
        se    <= second_in;
        delta <= delta_seconds;
        stat  <= ST_OK;
      end
      OP_QUOT: begin
        q25 <= 10'(({14'd0, yr} * RECIP25) >> RECIP_SHIFT);
      end
      OP_MOD: begin
        ym25 <= 5'(yr - 14'(q25) * YEAR_DIV);
        tod0 <= 17'(hr) * SECS_PER_HOUR + 17'(mi) * SECS_PER_MIN + 17'(se);
      end
      OP_START: begin
        u      <= {16'd0, tod0} + {delta[31], delta} + SEC_BIAS;
        hour   <= 5'd0;
        minute <= 6'd0;
        if (sts.bad) stat <= ST_BAD_INPUT;
      end
      OP_DIV: begin
        dq <= 17'(day_prod >> RECIP675_SHIFT);
      end
      OP_DREM: begin
        rem <= {day_sub[9:0], u[6:0]};
      end
      OP_HOUR: begin
        if (!sts.hour_done) begin
          rem  <= rem - SECS_PER_HOUR;
          hour <= hour + 5'd1;
        end
      end
      OP_MIN: begin
        if (!sts.min_done) begin
          rem    <= rem - SECS_PER_MIN;
          minute <= minute + 6'd1;
        end
      end
      OP_WINIT: begin
        // Day index within the starting month, after adding the whole days.
        e <= {1'b0, dq} + {13'd0, dy} - DAY_OFFSET;
      end
      OP_WALK: begin
        if (sts.walk_range) begin
          stat <= ST_RANGE;
        end else if (e_neg) begin
          e  <= e + {13'd0, prev_len};
          mo <= prev_mo;
          if (mo == MON_JAN) begin
            yr   <= yr - 14'd1;
            ym25 <= (ym25 == 5'd0) ? MOD25_TOP : ym25 - 5'd1;
          end
        end else if (e_over) begin
          e  <= e - {13'd0, cur_len};
          mo <= next_mo;
          if (mo == MON_DEC) begin
            yr   <= yr + 14'd1;
            ym25 <= (ym25 == MOD25_TOP) ? 5'd0 : ym25 + 5'd1;
          end
        end
      end
      OP_RESULT: begin
        status <= stat;
        if (stat == ST_OK) begin
          year_out   <= yr;
          month_out  <= mo;
          day_out    <= e[4:0] + 5'd1;
          hour_out   <= hour;
          minute_out <= minute;
          second_out <= rem[5:0];
        end else begin
          year_out   <= 14'd0;
          month_out  <= 4'd0;
          day_out    <= 5'd0;
          hour_out   <= 5'd0;
          minute_out <= 6'd0;
          second_out <= 6'd0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/datetime_add_signed_seconds_unit.sv
// Top level of the Gregorian date-time plus signed seconds unit.
//
//   channel  handshake            payload
//   in       in_valid / in_ready  year_in month_in day_in hour_in minute_in
//                                 second_in delta_seconds
//   out      out_valid/out_ready  year_out month_out day_out hour_out
//                                 minute_out second_out status
//
// One item at a time: setup loads and checks the inputs, the offset is split
// into days and seconds, hours then minutes are split off the time of day by
// repeated subtraction, and the month walk, which dominates, then steps one
// month boundary at a time. An invalid item skips straight to the result.
// The result waits in the output register while the next item is taken; that
// item stalls in its last cycle until the register is free.
// Reset (rst, synchronous) clears only the sequencer and the output valid.
`timescale 1ns / 1ps
module datetime_add_signed_seconds_unit import dtas_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  input  logic [4:0]  hour_in,
  input  logic [5:0]  minute_in,
  input  logic [5:0]  second_in,
  input  logic [31:0] delta_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out,
  output logic [1:0]  status
);

  op_t        op;
  dp_status_t sts;

  dtas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .op        (op)
  );

  dtas_dp u_dp (
    .clk           (clk),
    .op            (op),
    .sts           (sts),
    .year_in       (year_in),
    .month_in      (month_in),
    .day_in        (day_in),
    .hour_in       (hour_in),
    .minute_in     (minute_in),
    .second_in     (second_in),
    .delta_seconds (delta_seconds),
    .year_out      (year_out),
    .month_out     (month_out),
    .day_out       (day_out),
    .hour_out      (hour_out),
    .minute_out    (minute_out),
    .second_out    (second_out),
    .status        (status)
  );

endmodule

FILE: tb/tb_datetime_add_signed_seconds_unit.sv
// Self-checking testbench for the signed-seconds date-time offset unit.
`timescale 1ns / 1ps
module tb_datetime_add_signed_seconds_unit import dtas_pkg::*; ();

  localparam longint DAY_SECS = 86400;
  localparam longint HOUR_SECS = 3600;
  localparam longint MIN_SECS = 60;
  localparam longint LAST_YEAR = 9999;
  localparam longint ERA_DAYS = 146097;
  localparam int RANDOM_ITEMS = 555;
  localparam int STALL_AT = 150;
  localparam int STALL_CYCLES = 4000;
  localparam int QUIET_FROM = 350;
  localparam int QUIET_TO = 450;
  localparam int DRAIN_CYCLES = 60;
  localparam int unsigned TIMEOUT_CYCLES = 4_000_000;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] delta;
    logic        drain_first;
  } dt_request_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [1:0]  status;
  } dt_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [13:0] year_in = '0;
  logic [3:0]  month_in = '0;
  logic [4:0]  day_in = '0;
  logic [4:0]  hour_in = '0;
  logic [5:0]  minute_in = '0;
  logic [5:0]  second_in = '0;
  logic [31:0] delta_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [13:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;
  logic [1:0]  status;

  dt_request_t request_q[$];
  dt_result_t  shifted_dt_q[$];
  dt_request_t cur_req;
  int          sent_count = 0;
  int          got_count = 0;
  int          mismatch_count = 0;
  int          stall_left = 0;
  bit          stall_done = 1'b0;

  datetime_add_signed_seconds_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .year_in(year_in), .month_in(month_in), .day_in(day_in),
    .hour_in(hour_in), .minute_in(minute_in), .second_in(second_in),
    .delta_seconds(delta_seconds),
    .out_valid(out_valid), .out_ready(out_ready),
    .year_out(year_out), .month_out(month_out), .day_out(day_out),
    .hour_out(hour_out), .minute_out(minute_out), .second_out(second_out),
    .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit leap_year(longint y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int month_length(longint y, logic [3:0] m);
    case (m)
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
      MON_FEB: return leap_year(y) ? 29 : 28;
      default: return 31;
    endcase
  endfunction

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // Day count with 0000-03-01 as day zero; March-based years put the leap day last.
  function automatic longint serial_day(longint y, longint m, longint d);
    longint yy, era, yoe, mp, doy;
    yy = (m <= 2) ? y - 1 : y;
    era = floor_quot(yy, 400);
    yoe = yy - era * 400;
    mp = (m + 9) % 12;
    doy = (153 * mp + 2) / 5 + d - 1;
    return era * ERA_DAYS + yoe * 365 + yoe / 4 - yoe / 100 + doy;
  endfunction

  function automatic dt_result_t shift_datetime(dt_request_t rq);
    dt_result_t res;
    longint total, days, tod, era, doe, yoe, doy, mp, yr, mo, dd;
    res = '0;
    if (rq.year > LAST_YEAR || rq.month < 1 || rq.month > 12 || rq.day < 1 ||
        rq.day > month_length(longint'(rq.year), rq.month) || rq.hour >= 24 ||
        rq.minute >= 60 || rq.second >= 60) begin
      res.status = ST_BAD_INPUT;
      return res;
    end
    total = serial_day(longint'(rq.year), longint'(rq.month), longint'(rq.day)) * DAY_SECS
            + longint'(rq.hour) * HOUR_SECS + longint'(rq.minute) * MIN_SECS
            + longint'(rq.second) + longint'($signed(rq.delta));
    days = floor_quot(total, DAY_SECS);
    tod = total - days * DAY_SECS;
    era = floor_quot(days, ERA_DAYS);
    doe = days - era * ERA_DAYS;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    dd = doy - (153 * mp + 2) / 5 + 1;
    mo = (mp < 10) ? mp + 3 : mp - 9;
    yr = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
    if (yr < 0 || yr > LAST_YEAR) begin
      res.status = ST_RANGE;
      return res;
    end
    res.year = 14'(yr);
    res.month = 4'(mo);
    res.day = 5'(dd);
    res.hour = 5'(tod / HOUR_SECS);
    res.minute = 6'((tod / MIN_SECS) % 60);
    res.second = 6'(tod % MIN_SECS);
    res.status = ST_OK;
    return res;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int idx, int got, int want);
    if (got != want)
      flag_mismatch($sformatf("result %0d %s got %0d want %0d", idx, name, got, want));
  endtask

  task automatic queue_item(int y, int mo, int d, int h, int mi, int s,
                            logic [31:0] dl, bit drain = 1'b0);
    dt_request_t rq;
    rq.year = 14'(y);
    rq.month = 4'(mo);
    rq.day = 5'(d);
    rq.hour = 5'(h);
    rq.minute = 6'(mi);
    rq.second = 6'(s);
    rq.delta = dl;
    rq.drain_first = drain;
    request_q.push_back(rq);
  endtask

  // Sender: one item is held on the inputs until the block takes it.
  always @(posedge clk) begin
    bit take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        shifted_dt_q.push_back(shift_datetime(cur_req));
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        take = request_q.size() != 0 &&
               ((sent_count >= QUIET_FROM && sent_count < QUIET_TO) ||
                $urandom_range(99) >= 20);
        if (take && request_q[0].drain_first && shifted_dt_q.size() != 0) take = 1'b0;
        if (take) begin
          cur_req = request_q.pop_front();
          in_valid <= 1'b1;
          year_in <= cur_req.year;
          month_in <= cur_req.month;
          day_in <= cur_req.day;
          hour_in <= cur_req.hour;
          minute_in <= cur_req.minute;
          second_in <= cur_req.second;
          delta_seconds <= cur_req.delta;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold that fills the block.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!stall_done && got_count >= STALL_AT) begin
      stall_done <= 1'b1;
      stall_left <= STALL_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (got_count >= QUIET_FROM && got_count < QUIET_TO) ||
                   $urandom_range(99) >= 20;
    end
  end

  always @(posedge clk) begin
    dt_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (shifted_dt_q.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing expected", got_count));
      end else begin
        want = shifted_dt_q.pop_front();
        check_field("year", got_count, int'(year_out), int'(want.year));
        check_field("month", got_count, int'(month_out), int'(want.month));
        check_field("day", got_count, int'(day_out), int'(want.day));
        check_field("hour", got_count, int'(hour_out), int'(want.hour));
        check_field("minute", got_count, int'(minute_out), int'(want.minute));
        check_field("second", got_count, int'(second_out), int'(want.second));
        check_field("status", got_count, int'(status), int'(want.status));
      end
      got_count++;
    end
  end

  initial begin
    dt_request_t rq;
    int kind;
    // Zero offset, carries across year ends and leap rules.
    queue_item(2024, 2, 29, 12, 34, 56, 32'd0);
    queue_item(1999, 12, 31, 23, 59, 59, 32'd1);
    queue_item(2000, 1, 1, 0, 0, 0, -32'sd1);
    queue_item(2000, 2, 28, 23, 59, 59, 32'd1);
    queue_item(1900, 2, 28, 23, 59, 59, 32'd1);
    queue_item(0, 2, 28, 0, 0, 0, 32'd86400);
    // Widest offsets and the edges of the year range.
    queue_item(0, 1, 1, 0, 0, 0, 32'h7FFF_FFFF);
    queue_item(9999, 12, 31, 23, 59, 59, 32'h8000_0000);
    queue_item(0, 1, 1, 0, 0, 0, -32'sd1);
    queue_item(9999, 12, 31, 23, 59, 59, 32'd1);
    queue_item(5000, 6, 15, 7, 30, 0, 32'h7FFF_FFFF);
    // Each field out of its valid range, on its own but for one hour-and-minute item.
    queue_item(10000, 1, 1, 0, 0, 0, 32'd5);
    queue_item(16383, 12, 31, 23, 59, 59, 32'd5);
    queue_item(2020, 0, 1, 0, 0, 0, 32'd5);
    queue_item(2020, 13, 1, 0, 0, 0, 32'd5);
    queue_item(2020, 15, 31, 0, 0, 0, 32'd5);
    queue_item(2020, 3, 0, 0, 0, 0, 32'd5);
    queue_item(2021, 4, 31, 0, 0, 0, 32'd5);
    queue_item(2023, 2, 29, 0, 0, 0, 32'd5);
    queue_item(2024, 2, 30, 0, 0, 0, 32'd5);
    queue_item(2020, 5, 5, 24, 0, 0, 32'd5);
    queue_item(2020, 5, 5, 31, 63, 0, 32'd5);
    queue_item(2020, 5, 5, 0, 60, 0, 32'd5);
    queue_item(2020, 5, 5, 0, 0, 60, 32'd5);
    queue_item(2020, 5, 5, 0, 0, 63, 32'd5);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(99);
      case ($urandom_range(3))
        0: rq.year = 14'($urandom_range(67));
        1: rq.year = 14'(LAST_YEAR - $urandom_range(67));
        default: rq.year = 14'($urandom_range(LAST_YEAR));
      endcase
      rq.month = 4'($urandom_range(12, 1));
      rq.day = 5'($urandom_range(month_length(longint'(rq.year), rq.month), 1));
      rq.hour = 5'($urandom_range(23));
      rq.minute = 6'($urandom_range(59));
      rq.second = 6'($urandom_range(59));
      rq.drain_first = (n == 0 || n == 280);
      if (kind < 10) begin
        // Mostly malformed date-times, any bit pattern of every field.
        rq.year = 14'($urandom);
        rq.month = 4'($urandom);
        rq.day = 5'($urandom);
        rq.hour = 5'($urandom);
        rq.minute = 6'($urandom);
        rq.second = 6'($urandom);
        rq.delta = $urandom;
      end else if (kind < 55) begin
        rq.delta = $urandom_range(200000) - 100000;
      end else if (kind < 80) begin
        rq.delta = $urandom_range(1 << 27) - (1 << 26);
      end else begin
        rq.delta = $urandom;
      end
      request_q.push_back(rq);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (request_q.size() != 0 || in_valid || shifted_dt_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shifted_dt_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", shifted_dt_q.size()));
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
